/* src/sfr_pkg.sv */
// Shared constants, register codes and the job type for the stream find-and-replace block.
package sfr_pkg;

	localparam int MAX_KEY_LEN  = 8;
	localparam int MAX_REPL_LEN = 8;

	// Effective lengths never exceed eight characters.
	localparam int KEY_CAP  = (MAX_KEY_LEN < 8) ? MAX_KEY_LEN : 8;
	localparam int REPL_CAP = (MAX_REPL_LEN < 8) ? MAX_REPL_LEN : 8;
	localparam int JOB_LEN  = (KEY_CAP > REPL_CAP) ? KEY_CAP : REPL_CAP;
	localparam int LEN_W    = $clog2(JOB_LEN + 1);
	localparam int IDX_W    = (JOB_LEN > 1) ? $clog2(JOB_LEN) : 1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KEYWORD_BYTES      = 2'd0,
		CFG_KEYWORD_LENGTH     = 2'd1,
		CFG_REPLACEMENT_BYTES  = 2'd2,
		CFG_REPLACEMENT_LENGTH = 2'd3
	} cfg_reg_t;

	// One run of output characters caused by a single input item.
	typedef struct packed {
		logic [JOB_LEN-1:0][7:0] chars;
		logic [LEN_W-1:0]        cnt;
		logic                    line_end;
	} job_t;

endpackage

/* src/sfr_front.sv */
// Front end: configuration registers, match window and job classification.
module sfr_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     in_char,
	input  logic                           in_line_end,
	input  logic                           cfg_valid,
	input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           q_ready,
	output logic                           push,
	output sfr_pkg::job_t                  push_job
);

	logic [63:0] keyword_bytes_q;
	logic [3:0]  keyword_length_q;
	logic [63:0] replacement_bytes_q;
	logic [3:0]  replacement_length_q;

	logic [7:0]                    win_q [sfr_pkg::KEY_CAP];
	logic [sfr_pkg::LEN_W-1:0]     win_cnt_q;

	logic [7:0]                    new_win [sfr_pkg::KEY_CAP];
	logic [7:0]                    nxt_win [sfr_pkg::KEY_CAP];
	logic [sfr_pkg::LEN_W-1:0]     nxt_cnt;
	logic [sfr_pkg::LEN_W-1:0]     new_cnt;
	logic [sfr_pkg::LEN_W-1:0]     klen;
	logic [sfr_pkg::LEN_W-1:0]     rlen;
	logic [sfr_pkg::JOB_LEN-1:0][7:0] win_chars;
	logic [sfr_pkg::JOB_LEN-1:0][7:0] repl_chars;
	logic                          full;
	logic                          match;
	logic                          job_valid;
	logic                          accept;
	sfr_pkg::cfg_reg_t             cfg_reg;

	function automatic logic [sfr_pkg::LEN_W-1:0] eff_len(input logic [3:0] val, input int cap);
		int v;
		v = int'(val);
		if (v < 1) v = 1;
		if (v > cap) v = cap;
		return sfr_pkg::LEN_W'(v);
	endfunction

	assign cfg_reg  = sfr_pkg::cfg_reg_t'(cfg_index);
	assign in_ready = q_ready;
	assign accept   = in_valid && q_ready;
	assign push     = accept && job_valid;

	always_comb begin
		klen    = eff_len(keyword_length_q, sfr_pkg::KEY_CAP);
		rlen    = eff_len(replacement_length_q, sfr_pkg::REPL_CAP);
		new_cnt = win_cnt_q + sfr_pkg::LEN_W'(1);
		full    = (new_cnt == klen);
		match   = 1'b1;
		win_chars  = '0;
		repl_chars = '0;
		for (int j = 0; j < sfr_pkg::KEY_CAP; j++) begin
			new_win[j]   = (win_cnt_q == sfr_pkg::LEN_W'(j)) ? in_char : win_q[j];
			win_chars[j] = new_win[j];
			if ((sfr_pkg::LEN_W'(j) < klen) && (new_win[j] != keyword_bytes_q[8*j +: 8])) begin
				match = 1'b0;
			end
		end
		for (int j = 0; j < sfr_pkg::JOB_LEN; j++) begin
			repl_chars[j] = replacement_bytes_q[8*j +: 8];
		end

		// A window that is not full and does not end a line produces nothing yet.
		job_valid         = 1'b0;
		push_job.chars    = win_chars;
		push_job.cnt      = new_cnt;
		push_job.line_end = in_line_end;
		nxt_win           = new_win;
		nxt_cnt           = new_cnt;
		if (full && match) begin
			job_valid      = 1'b1;
			push_job.chars = repl_chars;
			push_job.cnt   = rlen;
			nxt_cnt        = '0;
		end else if (full) begin
			// Oldest character leaves; on a line end the whole window goes out in order.
			job_valid = 1'b1;
			for (int j = 0; j < sfr_pkg::KEY_CAP - 1; j++) begin
				nxt_win[j] = new_win[j+1];
			end
			if (in_line_end) begin
				push_job.cnt = klen;
				nxt_cnt      = '0;
			end else begin
				push_job.cnt = sfr_pkg::LEN_W'(1);
				nxt_cnt      = klen - sfr_pkg::LEN_W'(1);
			end
		end else if (in_line_end) begin
			job_valid = 1'b1;
			nxt_cnt   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keyword_bytes_q      <= '0;
			keyword_length_q     <= 4'd1;
			replacement_bytes_q  <= '0;
			replacement_length_q <= 4'd1;
		end else if (cfg_valid) begin
			unique case (cfg_reg)
				sfr_pkg::CFG_KEYWORD_BYTES:      keyword_bytes_q      <= cfg_data;
				sfr_pkg::CFG_KEYWORD_LENGTH:     keyword_length_q     <= cfg_data[3:0];
				sfr_pkg::CFG_REPLACEMENT_BYTES:  replacement_bytes_q  <= cfg_data;
				sfr_pkg::CFG_REPLACEMENT_LENGTH: replacement_length_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// A new keyword length drops whatever the window holds.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_cnt_q <= '0;
		end else if (cfg_valid && (cfg_reg == sfr_pkg::CFG_KEYWORD_LENGTH)) begin
			win_cnt_q <= '0;
		end else if (accept) begin
			win_cnt_q <= nxt_cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			win_q <= nxt_win;
		end
	end

endmodule

/* src/sfr_queue.sv */
// Short job queue between the front end and the output sequencer.
module sfr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sfr_pkg::job_t push_job,
	output logic          q_ready,
	input  logic          pop,
	output logic          q_valid,
	output sfr_pkg::job_t q_job
);

	sfr_pkg::job_t               mem_q [sfr_pkg::QUEUE_DEPTH];
	logic [sfr_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [sfr_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [sfr_pkg::QCNT_W-1:0]  count_q;

	function automatic logic [sfr_pkg::QPTR_W-1:0] ptr_inc(input logic [sfr_pkg::QPTR_W-1:0] p);
		if (p == sfr_pkg::QPTR_W'(sfr_pkg::QUEUE_DEPTH - 1)) return '0;
		return p + sfr_pkg::QPTR_W'(1);
	endfunction

	assign q_ready = (count_q != sfr_pkg::QCNT_W'(sfr_pkg::QUEUE_DEPTH));
	assign q_valid = (count_q != '0);
	assign q_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop) rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop) count_q <= count_q + sfr_pkg::QCNT_W'(1);
			else if (pop && !push) count_q <= count_q - sfr_pkg::QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

/* src/sfr_back.sv */
// Back end: steps through each queued job and emits one character per transfer.
module sfr_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  sfr_pkg::job_t q_job,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_char,
	output logic          out_line_end,
	output logic          run_last
);

	logic [sfr_pkg::IDX_W-1:0] idx_q;
	logic                      out_valid_q;
	logic [7:0]                out_char_q;
	logic                      out_line_end_q;
	logic                      run_last_q;
	logic                      load;
	logic                      last;

	assign load = q_valid && (!out_valid_q || out_ready);
	assign last = ((sfr_pkg::LEN_W'(idx_q) + sfr_pkg::LEN_W'(1)) == q_job.cnt);
	assign pop  = load && last;

	assign out_valid    = out_valid_q;
	assign out_char     = out_char_q;
	assign out_line_end = out_line_end_q;
	assign run_last     = run_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= last ? '0 : idx_q + sfr_pkg::IDX_W'(1);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_char_q     <= q_job.chars[idx_q];
			out_line_end_q <= last && q_job.line_end;
			run_last_q     <= last;
		end
	end

endmodule

/* src/stream_find_and_replace.sv */
// Top level of the streaming find-and-replace block.
// The first result of an item passes through the job queue and then the output register.
// Throughput: one item per cycle while out_ready holds and each item yields at most one
// character; an item that yields several characters holds the output sequencer until all
// of them are out, and a two-entry job queue lets the front end take items meanwhile.
// Reset: arst_n clears the window, the queue and the output register, and restores the
// configuration registers to a one-character keyword and replacement, each a zero byte.
module stream_find_and_replace (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     in_char,
	input  logic                           in_line_end,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [7:0]                     out_char,
	output logic                           out_line_end,
	output logic                           run_last,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic          push;
	logic          pop;
	logic          q_ready;
	logic          q_valid;
	sfr_pkg::job_t push_job;
	sfr_pkg::job_t q_job;

	// Register writes always complete in the cycle they are offered.
	assign cfg_ready = 1'b1;

	sfr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_char     (in_char),
		.in_line_end (in_line_end),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.q_ready     (q_ready),
		.push        (push),
		.push_job    (push_job)
	);

	sfr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.q_ready  (q_ready),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_job    (q_job)
	);

	sfr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_job        (q_job),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_char     (out_char),
		.out_line_end (out_line_end),
		.run_last     (run_last)
	);

endmodule

/* src/sfr_checker.sv */
// Port-level checker for the stream find-and-replace block, bound to the top level.
module sfr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_char,
	input logic       out_line_end,
	input logic       run_last
);

	// A stalled result keeps its character and flags.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char)
			&& $stable(out_line_end) && $stable(run_last))
		else $error("result changed while stalled");

	// The end of a rewritten line is always the last result of its item.
	a_line_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_line_end |-> run_last)
		else $error("line end on a result that is not the last of its item");

	// The characters of one item follow each other without a gap.
	a_run_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !run_last |=> out_valid)
		else $error("gap inside the results of one item");

	// From an empty output, a result needs an earlier input transfer.
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result appeared without a preceding input transfer");

endmodule

bind stream_find_and_replace sfr_checker u_sfr_checker (.*);
